// ----- src/tea_block_cipher_top_defines.svh -----
// Assertion macros used by the cipher top module.
`ifndef TEA_BLOCK_CIPHER_TOP_DEFINES_SVH
`define TEA_BLOCK_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tea_pkg.sv -----
package tea_pkg;

  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;

  // Block in flight: direction and the two words
  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } tea_stage_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

endpackage

// ----- src/tea_cell.sv -----
module tea_cell
  import tea_pkg::*;
#(
  parameter int ROUNDS    = 32,
  parameter int ROUND_IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv_i,
  input  tea_key_t   key_i,
  input  logic       vld_i,
  input  tea_stage_t data_i,
  output logic       vld_o,
  output tea_stage_t data_o
);

  // Round sums fixed per position in the chain
  localparam logic [63:0] ENC_PROD = 64'(TEA_DELTA) * 64'(ROUND_IDX + 1);
  localparam logic [63:0] DEC_PROD = 64'(TEA_DELTA) * 64'(ROUNDS - ROUND_IDX);
  localparam logic [WORD_W-1:0] SUM_ENC = ENC_PROD[WORD_W-1:0];
  localparam logic [WORD_W-1:0] SUM_DEC = DEC_PROD[WORD_W-1:0];

  function automatic logic [WORD_W-1:0] mix(
    input logic [WORD_W-1:0] w,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = (w << 4) + ka;
    b = w + sum;
    c = (w >> 5) + kb;
    return a ^ b ^ c;
  endfunction

  logic              mid_vld_r;
  tea_stage_t        mid_r;
  tea_stage_t        mid_nxt;
  logic              out_vld_r;
  tea_stage_t        out_r;
  tea_stage_t        out_nxt;
  logic [WORD_W-1:0] sum_a;
  logic [WORD_W-1:0] sum_b;
  logic [WORD_W-1:0] mix_a;
  logic [WORD_W-1:0] mix_b;

  // First half: encrypt updates v0 from v1, decrypt updates v1 from v0
  always_comb begin
    sum_a   = data_i.dec ? SUM_DEC : SUM_ENC;
    mix_a   = data_i.dec ? mix(data_i.v0, sum_a, key_i.k2, key_i.k3)
                         : mix(data_i.v1, sum_a, key_i.k0, key_i.k1);
    mid_nxt = data_i;
    if (data_i.dec) begin
      mid_nxt.v1 = data_i.v1 - mix_a;
    end else begin
      mid_nxt.v0 = data_i.v0 + mix_a;
    end
  end

  // Second half: the other word, from the one just updated
  always_comb begin
    sum_b   = mid_r.dec ? SUM_DEC : SUM_ENC;
    mix_b   = mid_r.dec ? mix(mid_r.v1, sum_b, key_i.k0, key_i.k1)
                        : mix(mid_r.v0, sum_b, key_i.k2, key_i.k3);
    out_nxt = mid_r;
    if (mid_r.dec) begin
      out_nxt.v0 = mid_r.v0 - mix_b;
    end else begin
      out_nxt.v1 = mid_r.v1 + mix_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv_i) begin
      mid_vld_r <= vld_i;
      out_vld_r <= mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      mid_r <= mid_nxt;
      out_r <= out_nxt;
    end
  end

  assign vld_o  = out_vld_r;
  assign data_o = out_r;

endmodule

// ----- src/tea_block_cipher_top.sv -----
// TEA block cipher, 64-bit block, 128-bit key.
// Input stream: in_tdata carries the block (v0 in bits 63..32, v1 in 31..0),
// in_tuser selects the direction (0 encrypt, 1 decrypt). Output stream:
// out_tdata carries the transformed block in the same word order.
// The key is four 32-bit words written through cfg_wr_en / cfg_addr /
// cfg_data (indexes 0 to 3, other indexes ignored); write it only while
// no block is in flight.
// The datapath is a chain of ROUNDS cells, one per TEA cycle, each split
// into two registered half rounds. One block is taken every cycle while
// the output is not stalled; throughput is set by the chain advancing as
// a whole.
// Reset clears all valid flags and loads the default key.
// When the receiver stalls with a result waiting, the whole chain holds
// and in_tready drops; it rises again in the cycle the result is taken.
`include "tea_block_cipher_top_defines.svh"

module tea_block_cipher_top
  import tea_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] block_in
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] block_out
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  localparam logic [7:0] REG_KEY0 = 8'd0;
  localparam logic [7:0] REG_KEY1 = 8'd1;
  localparam logic [7:0] REG_KEY2 = 8'd2;
  localparam logic [7:0] REG_KEY3 = 8'd3;

  localparam logic [WORD_W-1:0] KEY0_RST = 32'h95a8882c;
  localparam logic [WORD_W-1:0] KEY1_RST = 32'h9d2cc113;
  localparam logic [WORD_W-1:0] KEY2_RST = 32'h815aa0cd;
  localparam logic [WORD_W-1:0] KEY3_RST = 32'ha1c489f7;

  tea_key_t      key_r;
  logic          adv;
  logic          chain_vld [0:ROUNDS];
  tea_stage_t    chain_data [0:ROUNDS];
  logic [ROUNDS-1:0] vld_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.k0 <= KEY0_RST;
      key_r.k1 <= KEY1_RST;
      key_r.k2 <= KEY2_RST;
      key_r.k3 <= KEY3_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KEY0: key_r.k0 <= cfg_data;
        REG_KEY1: key_r.k1 <= cfg_data;
        REG_KEY2: key_r.k2 <= cfg_data;
        REG_KEY3: key_r.k3 <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Hold the whole chain while a result waits and is not taken
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign chain_vld[0]      = in_tvalid;
  assign chain_data[0].dec = in_tuser;
  assign chain_data[0].v0  = in_tdata[63:32];
  assign chain_data[0].v1  = in_tdata[31:0];

  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    tea_cell #(
      .ROUNDS    (ROUNDS),
      .ROUND_IDX (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_i  (adv),
      .key_i  (key_r),
      .vld_i  (chain_vld[g]),
      .data_i (chain_data[g]),
      .vld_o  (chain_vld[g+1]),
      .data_o (chain_data[g+1])
    );
    assign vld_vec[g] = chain_vld[g+1];
  end

  assign out_tvalid = chain_vld[ROUNDS];
  assign out_tdata  = {chain_data[ROUNDS].v0, chain_data[ROUNDS].v1};

  `TEA_ASSERT_NEXT(a_stall_holds_chain, out_tvalid && !out_tready, $stable(vld_vec),
                   "chain moved while the output was stalled")
  `TEA_ASSERT_NEXT(a_transfer_enters, in_tvalid && in_tready, g_cell[0].u_cell.mid_vld_r,
                   "accepted block did not enter the first cell")
  `TEA_ASSERT_NEXT(a_bubble_enters, !in_tvalid && in_tready, !g_cell[0].u_cell.mid_vld_r,
                   "first cell took a block without a transfer")
  `TEA_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready,
                  "input refused with no result waiting")

endmodule

// ----- bench/tea_block_cipher_checker.sv -----
`timescale 1ns / 100ps

package tea_tb_pkg;

  localparam logic [7:0] KEY_WORD0_IDX = 8'd0;
  localparam logic [7:0] KEY_WORD1_IDX = 8'd1;
  localparam logic [7:0] KEY_WORD2_IDX = 8'd2;
  localparam logic [7:0] KEY_WORD3_IDX = 8'd3;
  // first index past the key words; writes from here up are dropped
  localparam logic [7:0] KEY_IDX_LIMIT = 8'd4;

  localparam logic [31:0] KEY_WORD0_RESET = 32'h95a8882c;
  localparam logic [31:0] KEY_WORD1_RESET = 32'h9d2cc113;
  localparam logic [31:0] KEY_WORD2_RESET = 32'h815aa0cd;
  localparam logic [31:0] KEY_WORD3_RESET = 32'ha1c489f7;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } tea_op_t;

endpackage

module tea_block_cipher_checker
  import tea_pkg::*;
  import tea_tb_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] block_in
  input  logic        in_tuser,   // [0] opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [63:0] block_out
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [63:0] block_out;
    tea_op_t     op;
    logic [63:0] block_in;
  } cipher_result_t;

  tea_key_t       key_cur;
  cipher_result_t expected_blocks[$];
  cipher_result_t head;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [31:0] round_mix(logic [31:0] w, logic [31:0] s,
                                            logic [31:0] ka, logic [31:0] kb);
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

  function automatic logic [63:0] tea_transform(tea_op_t op, logic [63:0] blk,
                                                tea_key_t k);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] s;
    int          i;
    v0 = blk[63:32];
    v1 = blk[31:0];
    if (op == OP_DECRYPT) begin
      s = TEA_DELTA * 32'(ROUNDS);
      for (i = 0; i < ROUNDS; i++) begin
        v1 = v1 - round_mix(v0, s, k.k2, k.k3);
        v0 = v0 - round_mix(v1, s, k.k0, k.k1);
        s  = s - TEA_DELTA;
      end
    end else begin
      s = '0;
      for (i = 0; i < ROUNDS; i++) begin
        s  = s + TEA_DELTA;
        v0 = v0 + round_mix(v1, s, k.k0, k.k1);
        v1 = v1 + round_mix(v0, s, k.k2, k.k3);
      end
    end
    return {v0, v1};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tea checker: %s", msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_cur = '{k0: KEY_WORD0_RESET, k1: KEY_WORD1_RESET,
                  k2: KEY_WORD2_RESET, k3: KEY_WORD3_RESET};
      expected_blocks.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          KEY_WORD0_IDX: key_cur.k0 = cfg_data;
          KEY_WORD1_IDX: key_cur.k1 = cfg_data;
          KEY_WORD2_IDX: key_cur.k2 = cfg_data;
          KEY_WORD3_IDX: key_cur.k3 = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        head.op        = tea_op_t'(in_tuser);
        head.block_in  = in_tdata;
        head.block_out = tea_transform(head.op, in_tdata, key_cur);
        expected_blocks.push_back(head);
      end
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected block_out %h, nothing in flight",
                                    out_tdata));
        end else begin
          head = expected_blocks.pop_front();
          if (out_tdata !== head.block_out)
            report_mismatch($sformatf("block_out %h, expected %h (%s of %h)",
                                      out_tdata, head.block_out,
                                      head.op.name(), head.block_in));
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

// ----- bench/tb_tea_block_cipher_top.sv -----
`timescale 1ns / 100ps

module tb_tea_block_cipher_top
  import tea_pkg::*;
  import tea_tb_pkg::*;
();

  localparam int ROUNDS      = 32;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 140;
  localparam int EDGE_COUNT  = 9;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_wr_en  = 1'b0;
  logic [7:0]  cfg_addr   = '0;
  logic [31:0] cfg_data   = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  always #6 clk = ~clk;

  tea_block_cipher_top #(
    .ROUNDS(ROUNDS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  tea_block_cipher_checker #(
    .ROUNDS(ROUNDS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(negedge clk) out_tready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tea_block_cipher_top: FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] edge_block(int idx);
    case (idx)
      0:       return 64'h0000_0000_0000_0000;
      1:       return 64'hffff_ffff_ffff_ffff;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h0000_0000_0000_0001;
      4:       return 64'hffff_ffff_0000_0000;
      5:       return 64'h0000_0000_ffff_ffff;
      6:       return 64'haaaa_aaaa_aaaa_aaaa;
      7:       return 64'h5555_5555_5555_5555;
      default: return 64'h0123_4567_89ab_cdef;
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 8 : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 8 : 0;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_block(input tea_op_t op, input logic [63:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = blk;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [31:0] val);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic load_key(input tea_key_t k);
    cfg_write(KEY_WORD0_IDX, k.k0);
    cfg_write(KEY_WORD1_IDX, k.k1);
    cfg_write(KEY_WORD2_IDX, k.k2);
    cfg_write(KEY_WORD3_IDX, k.k3);
    // stray index must leave the key alone
    cfg_write(8'($urandom_range(255, KEY_IDX_LIMIT)), $urandom);
  endtask

  initial begin
    tea_key_t    key_next;
    logic [63:0] blk;
    int          i;
    int          p;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset key: edge blocks in both directions, back to back
    set_idle(IDLE_NONE);
    for (i = 0; i < EDGE_COUNT; i++) begin
      send_block(OP_ENCRYPT, edge_block(i));
      send_block(OP_DECRYPT, edge_block(i));
    end

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        1: key_next = '{k0: '0, k1: '0, k2: '0, k3: '0};
        2: key_next = '{k0: '1, k1: '1, k2: '1, k3: '1};
        5: key_next = '{k0: '0, k1: '1, k2: $urandom, k3: '0};
        6: key_next = '{k0: KEY_WORD0_RESET, k1: KEY_WORD1_RESET,
                        k2: KEY_WORD2_RESET, k3: KEY_WORD3_RESET};
        default: key_next = '{k0: $urandom, k1: $urandom, k2: $urandom, k3: $urandom};
      endcase
      if (p != 0) load_key(key_next);
      set_idle(idle_mode_t'(p % 4));

      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(7) == 0) blk = edge_block($urandom_range(EDGE_COUNT - 1));
        else                        blk = {$urandom, $urandom};
        send_block(tea_op_t'($urandom_range(1)), blk);
      end
    end

    stall_pct = 0;
    wait_drained();
    repeat (2 * ROUNDS + 16) @(negedge clk);

    if (fail_count == 0) begin
      $display("tb_tea_block_cipher_top: PASS");
    end else begin
      $display("tb_tea_block_cipher_top: FAIL");
    end
    $finish;
  end

endmodule
